FILE: src/i2cps_pkg.sv
package i2cps_pkg;

    // Number of bytes read in the data burst; the altitude uses the first three.
    localparam int SampleBytes = 5;
    localparam int SampleIdxW  = (SampleBytes > 1) ? $clog2(SampleBytes) : 1;
    localparam int BytePosW    = 3;

    // Fixed bytes on the bus.
    localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;
    localparam logic [7:0] ADDR_READ_BIT   = 8'h01;
    localparam logic [7:0] DATA_REG_ADDR   = 8'h01;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEVICE_ADDRESS   = 2'd0;
    localparam logic [1:0] CFG_CONTROL_REG_ADDR = 2'd1;
    localparam logic [1:0] CFG_ONE_SHOT_MASK    = 2'd2;
    localparam logic [1:0] CFG_RESTART_LIMIT    = 2'd3;

    // Configuration reset values.
    localparam logic [7:0]  RST_DEVICE_ADDRESS   = 8'd192;
    localparam logic [7:0]  RST_CONTROL_REG_ADDR = 8'd38;
    localparam logic [7:0]  RST_ONE_SHOT_MASK    = 8'd2;
    localparam logic [15:0] RST_RESTART_LIMIT    = 16'd512;

    typedef enum logic [1:0] {
        CMD_INTERRUPT   = 2'd0,
        CMD_BUS_EVENT   = 2'd1,
        CMD_CLEAR_COUNT = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_START  = 3'd1,
        ACT_RSTART = 3'd2,
        ACT_TX     = 3'd3,
        ACT_RX     = 3'd4,
        ACT_ACK    = 3'd5,
        ACT_NACK   = 3'd6,
        ACT_STOP   = 3'd7
    } action_t;

    typedef enum logic [4:0] {
        ST_DEV_WR      = 5'd0,
        ST_DATA_ADDR   = 5'd1,
        ST_DATA_RSTART = 5'd2,
        ST_DEV_RD      = 5'd3,
        ST_DATA_RX     = 5'd4,
        ST_DATA_BYTE   = 5'd5,
        ST_DATA_NEXT   = 5'd6,
        ST_CTL_RSTART  = 5'd7,
        ST_CTL_DEV_WR  = 5'd8,
        ST_CTL_ADDR    = 5'd9,
        ST_CTL_RSTART2 = 5'd10,
        ST_CTL_DEV_RD  = 5'd11,
        ST_CTL_RX      = 5'd12,
        ST_CTL_BYTE    = 5'd13,
        ST_WB_RSTART   = 5'd14,
        ST_WB_DEV_WR   = 5'd15,
        ST_WB_ADDR     = 5'd16,
        ST_WB_DATA     = 5'd17,
        ST_FINISH      = 5'd18
    } step_t;

    typedef struct packed {
        cmd_t       cmd;
        logic       int_level;
        logic       bus_granted;
        logic       nack_seen;
        logic       bus_collision;
        logic       write_collision;
        logic       rx_overflow;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        action_t            bus_action;
        logic [7:0]         tx_byte;
        logic               sample_done;
        logic signed [19:0] altitude;
        logic signed [31:0] altitude_sum;
        logic [15:0]        sample_count;
    } result_t;

    typedef struct packed {
        logic [7:0]  device_address;
        logic [7:0]  control_register_address;
        logic [7:0]  one_shot_mask;
        logic [15:0] restart_limit;
    } cfg_t;

endpackage

FILE: src/i2cps_seq_core.sv
module i2cps_seq_core
    import i2cps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    step_t                step_reg, step_next;
    logic                 session_reg, session_next;
    logic                 level_reg, level_next;
    logic [BytePosW-1:0]  byte_pos_reg, byte_pos_next;
    logic [31:0]          sum_reg, sum_next;
    logic [15:0]          count_reg, count_next;
    logic [7:0]           sample_reg [SampleBytes];
    logic [7:0]           control_reg;
    logic                 sample_we;
    logic                 control_we;

    logic                 bus_error;
    logic [7:0]           wr_addr;
    logic [7:0]           rd_addr;
    logic [BytePosW:0]    pos_plus_one;
    logic [19:0]          alt_raw;
    logic [31:0]          alt_ext;

    assign bus_error    = item.nack_seen | item.bus_collision | item.write_collision
                        | item.rx_overflow;
    assign wr_addr      = cfg.device_address & ADDR_WRITE_MASK;
    assign rd_addr      = cfg.device_address | ADDR_READ_BIT;
    assign pos_plus_one = {1'b0, byte_pos_reg} + (BytePosW+1)'(1);
    // Altitude is the top 20 bits of the first three bytes, big-endian.
    assign alt_raw      = {sample_reg[0], sample_reg[1], sample_reg[2][7:4]};
    assign alt_ext      = {{12{alt_raw[19]}}, alt_raw};

    always_comb
    begin
        step_next     = step_reg;
        session_next  = session_reg;
        level_next    = level_reg;
        byte_pos_next = byte_pos_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        sample_we     = 1'b0;
        control_we    = 1'b0;
        result.bus_action  = ACT_NONE;
        result.tx_byte     = 8'd0;
        result.sample_done = 1'b0;
        result.altitude    = 20'sd0;

        case (item.cmd)
            CMD_INTERRUPT:
            begin
                level_next = item.int_level;
                if (item.bus_granted)
                begin
                    step_next         = ST_DEV_WR;
                    session_next      = 1'b1;
                    result.bus_action = ACT_START;
                end
            end
            CMD_CLEAR_COUNT:
            begin
                count_next = 16'd0;
            end
            CMD_BUS_EVENT:
            begin
                if (session_reg && bus_error)
                begin
                    session_next      = 1'b0;
                    result.bus_action = ACT_STOP;
                end
                else if (session_reg)
                begin
                    case (step_reg)
                        ST_DEV_WR:
                        begin
                            result.bus_action = ACT_TX;
                            result.tx_byte    = wr_addr;
                            step_next         = ST_DATA_ADDR;
                        end
                        ST_DATA_ADDR:
                        begin
                            result.bus_action = ACT_TX;
                            result.tx_byte    = DATA_REG_ADDR;
                            step_next         = ST_DATA_RSTART;
                        end
                        ST_DATA_RSTART:
                        begin
                            result.bus_action = ACT_RSTART;
                            step_next         = ST_DEV_RD;
                        end
                        ST_DEV_RD:
                        begin
                            result.bus_action = ACT_TX;
                            result.tx_byte    = rd_addr;
                            step_next         = ST_DATA_RX;
                        end
                        ST_DATA_RX:
                        begin
                            result.bus_action = ACT_RX;
                            byte_pos_next     = '0;
                            step_next         = ST_DATA_BYTE;
                        end
                        ST_DATA_BYTE:
                        begin
                            sample_we     = ({1'b0, byte_pos_reg} < (BytePosW+1)'(SampleBytes));
                            byte_pos_next = pos_plus_one[BytePosW-1:0];
                            if (pos_plus_one < (BytePosW+1)'(SampleBytes))
                            begin
                                result.bus_action = ACT_ACK;
                                step_next         = ST_DATA_NEXT;
                            end
                            else
                            begin
                                result.bus_action = ACT_NACK;
                                step_next         = ST_CTL_RSTART;
                            end
                        end
                        ST_DATA_NEXT:
                        begin
                            result.bus_action = ACT_RX;
                            step_next         = ST_DATA_BYTE;
                        end
                        ST_CTL_RSTART:
                        begin
                            result.bus_action = ACT_RSTART;
                            step_next         = ST_CTL_DEV_WR;
                        end
                        ST_CTL_DEV_WR:
                        begin
                            result.bus_action = ACT_TX;
                            result.tx_byte    = wr_addr;
                            step_next         = ST_CTL_ADDR;
                        end
                        ST_CTL_ADDR:
                        begin
                            result.bus_action = ACT_TX;
                            result.tx_byte    = cfg.control_register_address;
                            step_next         = ST_CTL_RSTART2;
                        end
                        ST_CTL_RSTART2:
                        begin
                            result.bus_action = ACT_RSTART;
                            step_next         = ST_CTL_DEV_RD;
                        end
                        ST_CTL_DEV_RD:
                        begin
                            result.bus_action = ACT_TX;
                            result.tx_byte    = rd_addr;
                            step_next         = ST_CTL_RX;
                        end
                        ST_CTL_RX:
                        begin
                            result.bus_action = ACT_RX;
                            byte_pos_next     = '0;
                            step_next         = ST_CTL_BYTE;
                        end
                        ST_CTL_BYTE:
                        begin
                            control_we        = 1'b1;
                            result.bus_action = ACT_NACK;
                            step_next         = ST_WB_RSTART;
                        end
                        ST_WB_RSTART:
                        begin
                            result.bus_action = ACT_RSTART;
                            step_next         = ST_WB_DEV_WR;
                        end
                        ST_WB_DEV_WR:
                        begin
                            result.bus_action = ACT_TX;
                            result.tx_byte    = wr_addr;
                            step_next         = ST_WB_ADDR;
                        end
                        ST_WB_ADDR:
                        begin
                            result.bus_action = ACT_TX;
                            result.tx_byte    = cfg.control_register_address;
                            step_next         = ST_WB_DATA;
                        end
                        ST_WB_DATA:
                        begin
                            result.bus_action = ACT_TX;
                            result.tx_byte    = control_reg | cfg.one_shot_mask;
                            step_next         = ST_FINISH;
                        end
                        ST_FINISH:
                        begin
                            result.bus_action = ACT_STOP;
                            session_next      = 1'b0;
                            if (level_reg)
                            begin
                                result.sample_done = 1'b1;
                                result.altitude    = alt_raw;
                                if ((count_reg == 16'd0) || (count_reg > cfg.restart_limit))
                                begin
                                    sum_next = alt_ext;
                                end
                                else
                                begin
                                    sum_next = sum_reg + alt_ext;
                                end
                                count_next = count_reg + 16'd1;
                            end
                        end
                        default:
                        begin
                            result.bus_action = ACT_STOP;
                            session_next      = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                // Unused command: no effect.
            end
        endcase

        result.altitude_sum = sum_next;
        result.sample_count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= ST_DEV_WR;
            session_reg  <= 1'b0;
            level_reg    <= 1'b0;
            byte_pos_reg <= '0;
            sum_reg      <= 32'd0;
            count_reg    <= 16'd0;
        end
        else if (advance)
        begin
            step_reg     <= step_next;
            session_reg  <= session_next;
            level_reg    <= level_next;
            byte_pos_reg <= byte_pos_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
        end
    end

    // Received bytes need no reset: they are always written before use.
    always_ff @(posedge clk)
    begin
        if (advance && sample_we)
        begin
            sample_reg[byte_pos_reg[SampleIdxW-1:0]] <= item.rx_byte;
        end
        if (advance && control_we)
        begin
            control_reg <= item.rx_byte;
        end
    end

endmodule

FILE: src/i2c_pressure_sensor_read_sequencer_unit.sv
// Register-read sequencer for an I2C altitude sensor. Each input beat is one event: a
// sensor interrupt (tuser 0) latches the interrupt level and, when the bus was granted,
// opens a session with a start; a bus-event-complete beat (tuser 1) advances the
// nineteen-step read sequence and names the next bus action; a clear beat (tuser 2)
// zeroes the sample count. Every input beat produces exactly one output beat carrying
// the bus action, the byte to send, and the altitude, running sum and sample count.
// Throughput is one beat per clock cycle while the output is not held by back-pressure.
// An accepted beat is held in the input register, passes the single sequencing stage
// and is then held in the result register, from which it is offered on the output;
// output back-pressure stalls the input register and the result register either side
// of the sequencing stage. Configuration writes are applied on the clock edge at which
// cfg_write is high and should only be made while no beats are in flight.
module i2c_pressure_sensor_read_sequencer_unit
    import i2cps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] int_level, [1] bus_granted, [2] nack_seen, [3] bus_collision,
    // [4] write_collision, [5] rx_overflow, [13:6] rx_byte, [15:14] zero
    input  logic [15:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] bus_action, [10:3] tx_byte, [11] sample_done, [31:12] altitude,
    // [63:32] altitude_sum, [79:64] sample_count
    output logic [79:0] m_axis_tdata,

    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t core_result;
    cfg_t    cfg_reg;
    logic    in_accept;
    logic    advance;

    // The sequencing stage moves forward whenever it holds a beat and the result
    // register is empty or being emptied in the same cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg.cmd             <= cmd_t'(s_axis_tuser);
            in_item_reg.int_level       <= s_axis_tdata[0];
            in_item_reg.bus_granted     <= s_axis_tdata[1];
            in_item_reg.nack_seen       <= s_axis_tdata[2];
            in_item_reg.bus_collision   <= s_axis_tdata[3];
            in_item_reg.write_collision <= s_axis_tdata[4];
            in_item_reg.rx_overflow     <= s_axis_tdata[5];
            in_item_reg.rx_byte         <= s_axis_tdata[13:6];
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address           <= RST_DEVICE_ADDRESS;
            cfg_reg.control_register_address <= RST_CONTROL_REG_ADDR;
            cfg_reg.one_shot_mask            <= RST_ONE_SHOT_MASK;
            cfg_reg.restart_limit            <= RST_RESTART_LIMIT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS:   cfg_reg.device_address           <= cfg_data[7:0];
                CFG_CONTROL_REG_ADDR: cfg_reg.control_register_address <= cfg_data[7:0];
                CFG_ONE_SHOT_MASK:    cfg_reg.one_shot_mask            <= cfg_data[7:0];
                CFG_RESTART_LIMIT:    cfg_reg.restart_limit            <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The sequencing stage: session state, received bytes and the accumulator.
    i2cps_seq_core u_seq_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_result_reg.sample_count,
                            out_result_reg.altitude_sum,
                            out_result_reg.altitude,
                            out_result_reg.sample_done,
                            out_result_reg.tx_byte,
                            out_result_reg.bus_action};

    // A sample is only ever completed on the beat that closes the session.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_result_reg.sample_done) |->
            (out_result_reg.bus_action == ACT_STOP))
        else $error("sample completed without a stop");

    // A byte to send is only shown with a transmit action.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_result_reg.tx_byte != 8'd0)) |->
            (out_result_reg.bus_action == ACT_TX))
        else $error("transmit byte without a transmit action");

    // The altitude field is zero unless a sample was completed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !out_result_reg.sample_done) |->
            (out_result_reg.altitude == 20'sd0))
        else $error("altitude shown without a sample");

    // The input side only stalls when both registers are full and the output is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled with room in the pipeline");

endmodule
